FILE: rtl/sfr_pkg.sv
//------------------------------------------------------------------------------
// sfr_pkg: shared types and constants for the sensor frame rewriter
// Frame byte codes, data counter sizing, parse phase encoding and the result
// beat layout used between the parser, output stage and channel interfaces.
//------------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

	// frame layout
	localparam int unsigned FRAME_DATA_LEN = 17;
	localparam int unsigned CNT_W          = 5;

	localparam logic [7:0] HDR_BYTE = 8'h16;
	localparam logic [7:0] LEN_BYTE = 8'(FRAME_DATA_LEN);
	localparam logic [7:0] CMD_BYTE = 8'h0B;

	// data byte positions of the particle reading (high byte first)
	localparam logic [CNT_W-1:0] READING_HI_POS = CNT_W'(3);
	localparam logic [CNT_W-1:0] READING_LO_POS = CNT_W'(4);
	localparam logic [CNT_W-1:0] LAST_DATA_POS  = CNT_W'(FRAME_DATA_LEN);

	// parse phase, one-hot
	typedef enum logic [3:0] {
		PH_HUNT = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_CMD  = 4'b0100,
		PH_DATA = 4'b1000
	} phase_t;

	// one result beat
	typedef struct packed {
		logic [7:0]  tx_byte;
		logic        reading_valid;
		logic [15:0] particle_reading;
	} result_t;

	// parser status seen by the top level
	typedef struct packed {
		phase_t           phase;
		logic [CNT_W-1:0] data_count;
	} parse_stat_t;

endpackage

`default_nettype wire

FILE: rtl/sfr_rx_if.sv
//------------------------------------------------------------------------------
// sfr_rx_if: received byte channel
// Valid/ready channel carrying one byte from the sensor line per beat.
//------------------------------------------------------------------------------
`default_nettype none

interface sfr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfr_tx_if.sv
//------------------------------------------------------------------------------
// sfr_tx_if: transmitted byte channel
// Valid/ready channel carrying the forwarded byte and the latched reading.
//------------------------------------------------------------------------------
`default_nettype none

interface sfr_tx_if;
	logic        valid;
	logic        ready;
	logic [7:0]  tx_byte;
	logic        reading_valid;
	logic [15:0] particle_reading;

	modport source (output valid, output tx_byte, output reading_valid,
		output particle_reading, input ready);
	modport sink   (input valid, input tx_byte, input reading_valid,
		input particle_reading, output ready);
endinterface

`default_nettype wire

FILE: rtl/sfr_in_stage.sv
//------------------------------------------------------------------------------
// sfr_in_stage: input register
// Captures a received byte; refills in the same cycle the held byte moves on.
//------------------------------------------------------------------------------
`default_nettype none

module sfr_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// free or draining this cycle
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sfr_parser.sv
//------------------------------------------------------------------------------
// sfr_parser: frame parser and rewriter
// Tracks header/length/command, counts data bytes, substitutes the reading,
// recomputes the checksum and latches the reading at frame end.
//------------------------------------------------------------------------------
`default_nettype none

module sfr_parser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 advance,
	input  wire logic [7:0]           rx_byte,
	input  wire logic [15:0]          replacement_value,
	output sfr_pkg::result_t          result,
	output sfr_pkg::parse_stat_t      stat
);
	import sfr_pkg::*;

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] count_q, count_d, count_inc;
	logic [15:0]      accum_q, accum_d;
	logic [7:0]       sum_q, sum_d, sum_base;
	logic [15:0]      held_q, held_d;
	logic [7:0]       tx;
	logic             done;
	logic             repl_on;

	assign count_inc = count_q + CNT_W'(1);
	assign repl_on   = (replacement_value != 16'd0);

	// next state and outgoing byte
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		accum_d  = accum_q;
		sum_base = sum_q;
		held_d   = held_q;
		tx       = rx_byte;
		done     = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (rx_byte == HDR_BYTE) begin
					phase_d  = PH_LEN;
					count_d  = '0;
					accum_d  = '0;
					sum_base = '0;
				end
			end
			PH_LEN: begin
				phase_d = (rx_byte == LEN_BYTE) ? PH_CMD : PH_HUNT;
			end
			PH_CMD: begin
				phase_d = (rx_byte == CMD_BYTE) ? PH_DATA : PH_HUNT;
			end
			PH_DATA: begin
				count_d = count_inc;
				if (count_inc == READING_HI_POS) begin
					accum_d = accum_q + {rx_byte, 8'h00};
					if (repl_on) begin
						tx = replacement_value[15:8];
					end
				end
				if (count_inc == READING_LO_POS) begin
					accum_d = accum_q + {8'h00, rx_byte};
					if (repl_on) begin
						tx = replacement_value[7:0];
					end
				end
				// last data byte: checksum goes out, reading latched
				if (count_inc == LAST_DATA_POS) begin
					held_d  = accum_d;
					done    = 1'b1;
					phase_d = PH_HUNT;
					tx      = 8'h00 - sum_q;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		sum_d = sum_base + tx;
	end

	assign result.tx_byte          = tx;
	assign result.reading_valid    = done;
	assign result.particle_reading = held_d;
	assign stat.phase              = phase_q;
	assign stat.data_count         = count_q;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			accum_q <= '0;
			sum_q   <= '0;
			held_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
			accum_q <= accum_d;
			sum_q   <= sum_d;
			held_q  <= held_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sfr_out_stage.sv
//------------------------------------------------------------------------------
// sfr_out_stage: result register
// Holds one result beat until taken; reloads in the cycle it is taken.
//------------------------------------------------------------------------------
`default_nettype none

module sfr_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire sfr_pkg::result_t result,
	output logic                  can_load,
	sfr_tx_if.source              tx
);
	import sfr_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign can_load = !valid_q || tx.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= result;
		end
	end

	assign tx.valid            = valid_q;
	assign tx.tx_byte          = data_q.tx_byte;
	assign tx.reading_valid    = data_q.reading_valid;
	assign tx.particle_reading = data_q.particle_reading;

endmodule

`default_nettype wire

FILE: rtl/sensor_frame_rewriter_core.sv
//------------------------------------------------------------------------------
// sensor_frame_rewriter_core: in-line particle sensor frame rewriter
// Every received byte yields one transmitted byte. Frames are 0x16, length,
// 0x0B, then data; data bytes 3 and 4 may be replaced by replacement_value
// (when nonzero) and the last data byte is resent as a fresh checksum, at
// which point the reading is latched and flagged. A byte passes an input
// register, the parser logic and a result register; one byte is accepted
// every cycle while the result side keeps taking beats.
// The throughput is set by the parser state (phase, count, running sum),
// which updates once per byte. replacement_value is written via cfg_we.
//------------------------------------------------------------------------------
`default_nettype none

module sensor_frame_rewriter_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	sfr_rx_if.sink           rx,
	sfr_tx_if.source         tx,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata
);
	import sfr_pkg::*;

	logic        replacement_q;
	logic [15:0] repl_value_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	logic        can_load;
	result_t     result;
	parse_stat_t stat;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_value_q <= '0;
		end else if (cfg_we) begin
			repl_value_q <= cfg_wdata;
		end
	end
	assign replacement_q = (repl_value_q != 16'd0);

	// a byte moves when the result register can take it
	assign advance = valid_s1 && can_load;

	sfr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx.valid),
		.in_ready (rx.ready),
		.in_byte  (rx.rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	sfr_parser u_parser (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.rx_byte           (byte_s1),
		.replacement_value (repl_value_q),
		.result            (result),
		.stat              (stat)
	);

	sfr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.result   (result),
		.can_load (can_load),
		.tx       (tx)
	);

	// checks
	a_done_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.reading_valid |=> stat.phase == PH_HUNT)
		else $error("parser did not return to hunting after frame end");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat.phase == PH_DATA |-> stat.data_count < LAST_DATA_POS)
		else $error("data count passed frame length");

	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> tx.valid && !tx.ready)
		else $error("input stalled without output backpressure");

	a_replaced_hi: assert property (@(posedge clk) disable iff (!arst_n)
		advance && replacement_q && stat.phase == PH_DATA
		&& stat.data_count == READING_LO_POS - CNT_W'(2)
		|-> result.tx_byte == repl_value_q[15:8])
		else $error("reading high byte not replaced");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// testbench: sensor_frame_rewriter_core
// Streams serial bytes into the rewriter and checks every outgoing beat
// against an in-bench rewrite predictor. Covers framing mismatches, noise
// between frames and whole frames under several replacement settings.
// Both channels idle at random, then with no idling at all.
//------------------------------------------------------------------------------

module testbench;
	import sfr_pkg::*;

	// predicts the outgoing beat for each byte taken in, and holds them in order
	class rewrite_tracker;
		logic [15:0]      replacement;
		phase_t           phase;
		logic [CNT_W-1:0] count;
		logic [15:0]      accum;
		logic [7:0]       sent_sum;
		logic [15:0]      held;
		result_t          pending_tx[$];
		int unsigned      errors;

		function new();
			replacement = '0;
			phase       = PH_HUNT;
			count       = '0;
			accum       = '0;
			sent_sum    = '0;
			held        = '0;
			errors      = 0;
		endfunction

		function void set_replacement(logic [15:0] value);
			replacement = value;
		endfunction

		// advance the parser by one received byte, queue the beat it yields
		function void note_rx_beat(logic [7:0] rx_b);
			result_t    beat;
			logic [7:0] out_b;
			logic       done;
			out_b = rx_b;
			done  = 1'b0;
			if (phase == PH_HUNT && rx_b == HDR_BYTE) begin
				phase    = PH_LEN;
				count    = '0;
				accum    = '0;
				sent_sum = '0;
			end else if (phase == PH_LEN && rx_b == LEN_BYTE) begin
				phase = PH_CMD;
			end else if (phase == PH_CMD && rx_b == CMD_BYTE) begin
				phase = PH_DATA;
			end else if (phase == PH_DATA) begin
				count = count + 1'b1;
				if (count == READING_HI_POS) begin
					accum = accum + {rx_b, 8'h00};
					if (replacement != 0)
						out_b = replacement[15:8];
				end
				if (count == READING_LO_POS) begin
					accum = accum + {8'h00, rx_b};
					if (replacement != 0)
						out_b = replacement[7:0];
				end
				// last data byte: checksum goes out, reading is latched
				if (count == LAST_DATA_POS) begin
					held  = accum;
					done  = 1'b1;
					phase = PH_HUNT;
					out_b = 8'h00 - sent_sum;
				end
			end else begin
				phase = PH_HUNT;
			end
			sent_sum = sent_sum + out_b;
			beat.tx_byte          = out_b;
			beat.reading_valid    = done;
			beat.particle_reading = held;
			pending_tx.push_back(beat);
		endfunction

		// compare one outgoing beat with the oldest prediction
		function void check_tx_beat(result_t got);
			result_t want;
			if (pending_tx.size() == 0) begin
				$display("%0t: unexpected beat, expected none, got %02h/%0b/%04h",
					$time, got.tx_byte, got.reading_valid, got.particle_reading);
				errors++;
				return;
			end
			want = pending_tx.pop_front();
			if (got.tx_byte !== want.tx_byte) begin
				$display("%0t: tx_byte mismatch, expected %02h, got %02h",
					$time, want.tx_byte, got.tx_byte);
				errors++;
			end
			if (got.reading_valid !== want.reading_valid) begin
				$display("%0t: reading_valid mismatch, expected %0b, got %0b",
					$time, want.reading_valid, got.reading_valid);
				errors++;
			end
			if (got.particle_reading !== want.particle_reading) begin
				$display("%0t: particle_reading mismatch, expected %04h, got %04h",
					$time, want.particle_reading, got.particle_reading);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	sfr_rx_if rx_ch();
	sfr_tx_if tx_ch();

	sensor_frame_rewriter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.tx        (tx_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	rewrite_tracker tracker;
	int unsigned    send_idle_pct;
	int unsigned    rcv_stall_pct;
	int unsigned    bytes_sent;

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	// beat monitor on both channels; receiver stalls are drawn here too
	always @(posedge clk) begin : beat_monitor
		result_t got;
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready)
				tracker.note_rx_beat(rx_ch.rx_byte);
			if (tx_ch.valid && tx_ch.ready) begin
				got.tx_byte          = tx_ch.tx_byte;
				got.reading_valid    = tx_ch.reading_valid;
				got.particle_reading = tx_ch.particle_reading;
				tracker.check_tx_beat(got);
			end
		end
		tx_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// one byte onto the rx channel, with random gaps ahead of it
	task automatic send_byte(input logic [7:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= value;
		do @(posedge clk); while (!rx_ch.ready);
		bytes_sent++;
	endtask

	// hold off the sender until every predicted beat has come out
	task automatic drain();
		rx_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_tx.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_replacement(input logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tracker.set_replacement(value);
	endtask

	// header, length, command, then data; reading bytes given by the caller
	task automatic send_frame(input logic [7:0] hi_b, input logic [7:0] lo_b);
		send_byte(HDR_BYTE);
		send_byte(LEN_BYTE);
		send_byte(CMD_BYTE);
		for (int unsigned pos = 1; pos <= FRAME_DATA_LEN; pos++) begin
			if (pos == READING_HI_POS)
				send_byte(hi_b);
			else if (pos == READING_LO_POS)
				send_byte(lo_b);
			else
				send_byte(8'($urandom_range(255)));
		end
	endtask

	// mostly whole frames, some noise, some frames cut off in the preamble
	task automatic send_random_traffic(input int unsigned stop_at);
		int unsigned pick;
		int unsigned burst;
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_frame(8'($urandom_range(255)), 8'($urandom_range(255)));
			end else if (pick < 85) begin
				burst = $urandom_range(6, 1);
				repeat (burst) begin
					if ($urandom_range(3) == 0)
						send_byte(HDR_BYTE);
					else
						send_byte(8'($urandom_range(255)));
				end
			end else begin
				send_byte(HDR_BYTE);
				if ($urandom_range(1) == 0) begin
					send_byte(8'($urandom_range(255)));
				end else begin
					send_byte(LEN_BYTE);
					send_byte(8'($urandom_range(255)));
				end
			end
		end
	endtask

	// stimulus
	initial begin
		logic [15:0] rep_values [6];
		tracker          = new();
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		rx_ch.valid      = 1'b0;
		rx_ch.rx_byte    = '0;
		tx_ch.ready      = 1'b0;
		send_idle_pct    = 0;
		rcv_stall_pct    = 0;
		bytes_sent       = 0;
		rep_values[0]    = 16'hFFFF;
		rep_values[1]    = 16'h0001;
		rep_values[2]    = 16'($urandom_range(65535, 1));
		rep_values[3]    = 16'h0000;
		rep_values[4]    = 16'h8000;
		rep_values[5]    = 16'($urandom_range(65535));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, header not retried after a bad length,
		// bad command, then one clean frame with the reset replacement
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR_BYTE);
		send_byte(HDR_BYTE);
		send_byte(LEN_BYTE);
		send_byte(HDR_BYTE);
		send_byte(LEN_BYTE);
		send_byte(8'h00);
		send_frame(8'hFF, 8'h00);
		drain();

		// random traffic over three idling modes, two replacement settings each
		for (int mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin
					send_idle_pct = 36;
					rcv_stall_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					rcv_stall_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					rcv_stall_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 2; seg++) begin
				write_replacement(rep_values[mode * 2 + seg]);
				send_random_traffic(bytes_sent + 208);
				drain();
			end
		end

		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sfr_pkg.sv
rtl/sfr_rx_if.sv
rtl/sfr_tx_if.sv
rtl/sfr_in_stage.sv
rtl/sfr_parser.sv
rtl/sfr_out_stage.sv
rtl/sensor_frame_rewriter_core.sv
tb/testbench.sv
